@@ sv/lrvs_pkg.sv @@
// ----------------------------------------------------------------------------
// lrvs_pkg: shared types and constants of the linear range selector map
// Field widths, register indexes, kind bits, status codes and the tag
// that travels through the divider next to each item.
// ----------------------------------------------------------------------------
package lrvs_pkg;

    localparam int SEL_BITS   = 16;
    localparam int VAL_BITS   = 32;
    localparam int OP_BITS    = 32;
    localparam int KIND_BITS  = 3;
    localparam int STAT_BITS  = 2;
    localparam int CFG_IDX_BITS = 2;
    localparam int DIV_STAGES = OP_BITS;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_RANGE_BASE       = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOWEST_SELECTOR  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_HIGHEST_SELECTOR = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_VALUE_STEP       = 2'd3;

    // kind bit positions
    localparam int KIND_HIGH_BIT  = 0;   // high edge / ceiling
    localparam int KIND_CLAMP_BIT = 1;
    localparam int KIND_SEL_BIT   = 2;   // value to selector direction

    // status codes
    localparam logic [STAT_BITS-1:0] ST_IN_RANGE  = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_CLAMPED   = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_NO_ANSWER = 2'd2;

    typedef struct packed {
        logic                 need_div;
        logic                 ceil_mode;
        logic [STAT_BITS-1:0] status;
        logic [OP_BITS-1:0]   answer;
    } lrvs_tag_t;

endpackage

@@ sv/lrvs_div.sv @@
// ----------------------------------------------------------------------------
// lrvs_div: pipelined unsigned divider
// Restoring division, one quotient bit per stage. The dividend shifts out
// of the top of the word while quotient bits shift in at the bottom. A tag
// rides along with each item; the whole pipe moves only when enabled.
// ----------------------------------------------------------------------------
module lrvs_div
    import lrvs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               enable,
    input  logic               src_valid,
    input  logic [OP_BITS-1:0] dividend,
    input  logic [OP_BITS-1:0] divisor,
    input  lrvs_tag_t          src_tag,
    output logic               res_valid,
    output logic [OP_BITS-1:0] quotient,
    output logic [OP_BITS-1:0] remainder,
    output lrvs_tag_t          res_tag
);

    logic               valid_reg [DIV_STAGES];
    logic [OP_BITS-1:0] rem_reg   [DIV_STAGES];
    logic [OP_BITS-1:0] word_reg  [DIV_STAGES];
    lrvs_tag_t          tag_reg   [DIV_STAGES];

    genvar s;
    generate
        for (s = 0; s < DIV_STAGES; s++)
        begin : g_stage
            logic               valid_src;
            logic [OP_BITS-1:0] rem_src;
            logic [OP_BITS-1:0] word_src;
            lrvs_tag_t          tag_src;
            logic [OP_BITS:0]   trial;
            logic [OP_BITS:0]   diff;
            logic               ge;
            logic [OP_BITS-1:0] rem_next;
            logic [OP_BITS-1:0] word_next;

            if (s == 0)
            begin : g_first
                assign valid_src = src_valid;
                assign rem_src   = '0;
                assign word_src  = dividend;
                assign tag_src   = src_tag;
            end
            else
            begin : g_rest
                assign valid_src = valid_reg[s-1];
                assign rem_src   = rem_reg[s-1];
                assign word_src  = word_reg[s-1];
                assign tag_src   = tag_reg[s-1];
            end

            always_comb
            begin
                trial     = {rem_src, word_src[OP_BITS-1]};
                diff      = trial - {1'b0, divisor};
                ge        = (trial >= {1'b0, divisor});
                rem_next  = ge ? diff[OP_BITS-1:0] : trial[OP_BITS-1:0];
                word_next = {word_src[OP_BITS-2:0], ge};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[s] <= 1'b0;
                end
                else if (enable)
                begin
                    valid_reg[s] <= valid_src;
                end
            end

            always_ff @(posedge clk)
            begin
                if (enable)
                begin
                    rem_reg[s]  <= rem_next;
                    word_reg[s] <= word_next;
                    tag_reg[s]  <= tag_src;
                end
            end
        end
    endgenerate

    assign res_valid = valid_reg[DIV_STAGES-1];
    assign quotient  = word_reg[DIV_STAGES-1];
    assign remainder = rem_reg[DIV_STAGES-1];
    assign res_tag   = tag_reg[DIV_STAGES-1];

endmodule

@@ sv/linear_range_value_selector_map_unit.sv @@
// ----------------------------------------------------------------------------
// linear_range_value_selector_map_unit: linear range selector/value mapper
// Converts a selector to its value (low or high edge of its step) or a
// value back to its selector (floor or ceiling), strict or clamping.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: kind and operand with in_valid; the unit drives in_stall.
//   Output channel: answer and status with out_valid; the receiver drives
//   out_stall. An item moves at a clock edge with valid high and stall low.
//   Configuration: cfg_we writes cfg_data into the register chosen by
//   cfg_index at the clock edge; write only while no item is in flight.
//   Pipeline: an accepted item passes six front stages (input register,
//   compares, two multipliers, adds, edge adjust, result select), one
//   stage per quotient bit of the 32-bit divider, then the output register.
//   Throughput: one item per cycle while in_stall is low; every item goes
//   through the divider pipe, so all items take the same path and leave
//   in order.
//   Stall: the output register is backed by one skid register. When the
//   receiver stalls, one more result lands in the skid register, after
//   which in_stall rises and the whole pipe holds until the skid drains.
//   Reset: all configuration registers read zero, the pipe is empty.
// ----------------------------------------------------------------------------
module linear_range_value_selector_map_unit
    import lrvs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [VAL_BITS-1:0]     cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [KIND_BITS-1:0]    kind,
    input  logic [OP_BITS-1:0]      operand,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [OP_BITS-1:0]      answer,
    output logic [STAT_BITS-1:0]    status
);

    // configuration registers
    logic [VAL_BITS-1:0] range_base_reg;
    logic [SEL_BITS-1:0] lowest_selector_reg;
    logic [SEL_BITS-1:0] highest_selector_reg;
    logic [VAL_BITS-1:0] value_step_reg;
    logic [VAL_BITS-1:0] step_m1_reg;
    logic                step_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_base_reg       <= '0;
            lowest_selector_reg  <= '0;
            highest_selector_reg <= '0;
            value_step_reg       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RANGE_BASE:       range_base_reg       <= cfg_data;
                REG_LOWEST_SELECTOR:  lowest_selector_reg  <= cfg_data[SEL_BITS-1:0];
                REG_HIGHEST_SELECTOR: highest_selector_reg <= cfg_data[SEL_BITS-1:0];
                REG_VALUE_STEP:       value_step_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // derived from the step, settled long before an item reaches its use
    always_ff @(posedge clk)
    begin
        step_m1_reg   <= value_step_reg - VAL_BITS'(1);
        step_zero_reg <= (value_step_reg == '0);
    end

    logic [OP_BITS-1:0] low_ext;
    logic [OP_BITS-1:0] high_ext;

    assign low_ext  = OP_BITS'(lowest_selector_reg);
    assign high_ext = OP_BITS'(highest_selector_reg);

    // pipe moves whenever the skid register is free
    logic skid_valid_reg;
    logic adv;

    assign adv      = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    // ---------------- input register ----------------
    logic                 p1_valid_reg;
    logic [KIND_BITS-1:0] p1_kind_reg;
    logic [OP_BITS-1:0]   p1_op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_kind_reg <= kind;
            p1_op_reg   <= operand;
        end
    end

    // ---------------- stage a: compares and differences ----------------
    logic                 a_valid_reg;
    logic [KIND_BITS-1:0] a_kind_reg;
    logic [OP_BITS-1:0]   a_op_reg;
    logic                 a_below_sel_reg, a_below_sel_next;
    logic                 a_above_sel_reg, a_above_sel_next;
    logic                 a_below_val_reg, a_below_val_next;
    logic [OP_BITS-1:0]   a_diff_reg, a_diff_next;
    logic [OP_BITS-1:0]   a_span_reg, a_span_next;
    logic [OP_BITS-1:0]   a_n_reg, a_n_next;

    always_comb
    begin
        a_below_sel_next = (p1_op_reg < low_ext);
        a_above_sel_next = (p1_op_reg > high_ext);
        a_below_val_next = (p1_op_reg < OP_BITS'(range_base_reg));
        a_diff_next      = p1_op_reg - low_ext;
        a_span_next      = high_ext - low_ext;
        a_n_next         = p1_op_reg - OP_BITS'(range_base_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_kind_reg      <= p1_kind_reg;
            a_op_reg        <= p1_op_reg;
            a_below_sel_reg <= a_below_sel_next;
            a_above_sel_reg <= a_above_sel_next;
            a_below_val_reg <= a_below_val_next;
            a_diff_reg      <= a_diff_next;
            a_span_reg      <= a_span_next;
            a_n_reg         <= a_n_next;
        end
    end

    // ---------------- stage b: products ----------------
    logic                 b_valid_reg;
    logic [KIND_BITS-1:0] b_kind_reg;
    logic [OP_BITS-1:0]   b_op_reg;
    logic                 b_below_sel_reg;
    logic                 b_above_sel_reg;
    logic                 b_below_val_reg;
    logic [OP_BITS-1:0]   b_n_reg;
    logic [VAL_BITS-1:0]  b_prod_reg, b_prod_next;
    logic [VAL_BITS-1:0]  b_lprod_reg, b_lprod_next;

    always_comb
    begin
        b_prod_next  = VAL_BITS'(a_diff_reg * value_step_reg);
        b_lprod_next = VAL_BITS'(a_span_reg * value_step_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_kind_reg      <= a_kind_reg;
            b_op_reg        <= a_op_reg;
            b_below_sel_reg <= a_below_sel_reg;
            b_above_sel_reg <= a_above_sel_reg;
            b_below_val_reg <= a_below_val_reg;
            b_n_reg         <= a_n_reg;
            b_prod_reg      <= b_prod_next;
            b_lprod_reg     <= b_lprod_next;
        end
    end

    // ---------------- stage c: value and limit ----------------
    logic                 c_valid_reg;
    logic [KIND_BITS-1:0] c_kind_reg;
    logic [OP_BITS-1:0]   c_op_reg;
    logic                 c_below_sel_reg;
    logic                 c_above_sel_reg;
    logic                 c_below_val_reg;
    logic [OP_BITS-1:0]   c_n_reg;
    logic [VAL_BITS-1:0]  c_val_reg, c_val_next;
    logic [VAL_BITS-1:0]  c_limit_reg, c_limit_next;

    always_comb
    begin
        c_val_next   = range_base_reg + b_prod_reg;
        c_limit_next = range_base_reg + b_lprod_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_kind_reg      <= b_kind_reg;
            c_op_reg        <= b_op_reg;
            c_below_sel_reg <= b_below_sel_reg;
            c_above_sel_reg <= b_above_sel_reg;
            c_below_val_reg <= b_below_val_reg;
            c_n_reg         <= b_n_reg;
            c_val_reg       <= c_val_next;
            c_limit_reg     <= c_limit_next;
        end
    end

    // ---------------- stage d: high edge and limit compare ----------------
    logic                 d_valid_reg;
    logic [KIND_BITS-1:0] d_kind_reg;
    logic                 d_below_sel_reg;
    logic                 d_above_sel_reg;
    logic                 d_below_val_reg;
    logic                 d_above_val_reg, d_above_val_next;
    logic [OP_BITS-1:0]   d_n_reg;
    logic [VAL_BITS-1:0]  d_val_reg;
    logic [VAL_BITS-1:0]  d_val_high_reg, d_val_high_next;
    logic [VAL_BITS-1:0]  d_limit_reg;

    always_comb
    begin
        d_above_val_next = (c_op_reg > OP_BITS'(c_limit_reg));
        d_val_high_next  = c_val_reg + step_m1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_kind_reg      <= c_kind_reg;
            d_below_sel_reg <= c_below_sel_reg;
            d_above_sel_reg <= c_above_sel_reg;
            d_below_val_reg <= c_below_val_reg;
            d_above_val_reg <= d_above_val_next;
            d_n_reg         <= c_n_reg;
            d_val_reg       <= c_val_reg;
            d_val_high_reg  <= d_val_high_next;
            d_limit_reg     <= c_limit_reg;
        end
    end

    // ---------------- stage e: result select ----------------
    logic               e_valid_reg;
    logic [OP_BITS-1:0] e_n_reg;
    lrvs_tag_t          e_tag_reg, e_tag_next;
    logic               d_high;
    logic               d_clamp;
    logic [STAT_BITS-1:0] d_out_status;

    assign d_high       = d_kind_reg[KIND_HIGH_BIT];
    assign d_clamp      = d_kind_reg[KIND_CLAMP_BIT];
    assign d_out_status = d_clamp ? ST_CLAMPED : ST_NO_ANSWER;

    always_comb
    begin
        e_tag_next.need_div  = 1'b0;
        e_tag_next.ceil_mode = d_high;
        e_tag_next.status    = ST_IN_RANGE;
        e_tag_next.answer    = '0;
        if (d_kind_reg[KIND_SEL_BIT])
        begin
            if (d_below_val_reg)
            begin
                e_tag_next.status = d_out_status;
                e_tag_next.answer = d_clamp ? low_ext : '0;
            end
            else if (d_above_val_reg)
            begin
                e_tag_next.status = d_out_status;
                e_tag_next.answer = d_clamp ? high_ext : '0;
            end
            else if (step_zero_reg)
            begin
                e_tag_next.answer = d_high ? high_ext : low_ext;
            end
            else
            begin
                e_tag_next.need_div = 1'b1;
            end
        end
        else
        begin
            if (d_below_sel_reg)
            begin
                e_tag_next.status = d_out_status;
                e_tag_next.answer = d_clamp ? OP_BITS'(range_base_reg) : '0;
            end
            else if (d_above_sel_reg)
            begin
                e_tag_next.status = d_out_status;
                e_tag_next.answer = d_clamp ? OP_BITS'(d_limit_reg) : '0;
            end
            else
            begin
                e_tag_next.answer = d_high ? OP_BITS'(d_val_high_reg)
                                           : OP_BITS'(d_val_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_n_reg   <= d_n_reg;
            e_tag_reg <= e_tag_next;
        end
    end

    // ---------------- divider ----------------
    logic               dv_valid;
    logic [OP_BITS-1:0] dv_quot;
    logic [OP_BITS-1:0] dv_rem;
    lrvs_tag_t          dv_tag;

    lrvs_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .enable    (adv),
        .src_valid (e_valid_reg),
        .dividend  (e_n_reg),
        .divisor   (OP_BITS'(value_step_reg)),
        .src_tag   (e_tag_reg),
        .res_valid (dv_valid),
        .quotient  (dv_quot),
        .remainder (dv_rem),
        .res_tag   (dv_tag)
    );

    // ---------------- final answer ----------------
    logic [OP_BITS-1:0]   fin_answer;
    logic [STAT_BITS-1:0] fin_status;
    logic                 ceil_inc;

    always_comb
    begin
        ceil_inc   = dv_tag.ceil_mode && (dv_rem != '0);
        fin_status = dv_tag.status;
        if (dv_tag.need_div)
        begin
            fin_answer = low_ext + dv_quot + OP_BITS'(ceil_inc);
        end
        else
        begin
            fin_answer = dv_tag.answer;
        end
    end

    // ---------------- output register and skid ----------------
    logic                 out_valid_reg;
    logic [OP_BITS-1:0]   out_answer_reg;
    logic [STAT_BITS-1:0] out_status_reg;
    logic [OP_BITS-1:0]   skid_answer_reg;
    logic [STAT_BITS-1:0] skid_status_reg;
    logic                 out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || dv_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (dv_valid && adv)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_answer_reg <= skid_answer_reg;
                out_status_reg <= skid_status_reg;
            end
            else
            begin
                out_answer_reg <= fin_answer;
                out_status_reg <= fin_status;
            end
        end
        else if (adv)
        begin
            skid_answer_reg <= fin_answer;
            skid_status_reg <= fin_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign answer    = out_answer_reg;
    assign status    = out_status_reg;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds an item while the output is empty");

    a_no_answer_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg == ST_NO_ANSWER) |-> (out_answer_reg == '0))
        else $error("item without answer carries a nonzero answer");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_status_reg == ST_IN_RANGE || out_status_reg == ST_CLAMPED
                           || out_status_reg == ST_NO_ANSWER))
        else $error("unknown status code on output");

    a_skid_catch: assert property (@(posedge clk) disable iff (!rst_n)
        !skid_valid_reg && dv_valid && out_valid_reg && out_stall |=> skid_valid_reg)
        else $error("item leaving the pipe under stall was not caught");

    a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_stall |=> skid_valid_reg)
        else $error("skid item dropped while output stalled");
`endif

endmodule
